// File: src/dfx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the delimited field extractor.
// Depends on nothing; every other file in src imports it.
package dfx_pkg;

  localparam int DATA_W       = 8;
  localparam int FIDX_W       = 16;
  localparam int FNUM_W       = 17;
  localparam int DELIM_W      = 64;
  localparam int LEN_W        = 4;
  localparam int MAX_DELIM_DEF = 8;

  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_TUSER_W  = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 64;

  localparam logic [FNUM_W-1:0] FIELD_MAX = {FNUM_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              byte_present;
    logic              row_start;
    logic              row_end;
    logic [FIDX_W-1:0] field_index;
    logic              row_is_null;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              byte_vld;
    logic              res_end;
    logic              res_null;
  } res_t;

  // One engine step as seen by the output stage.
  typedef struct packed {
    logic busy;   // an item is being worked on
    logic vld;    // this step produces a result
    logic done;   // the item is finished after this step
    res_t res;
  } eng_out_t;

endpackage

// File: src/delimited_field_extractor.sv
`timescale 1ns / 1ps
// Top level of the delimited field extractor: stream ports, configuration
// port and the wiring of dfx_cfg, dfx_engine and dfx_tagger. Uses dfx_pkg.
//
// A row string enters one byte per transaction on the in_ channel; the block
// returns the bytes of the wanted field on the out_ channel, followed by an
// end marker (out_tlast) that carries the null flag in out_tuser. The
// delimiter (1 to MAX_DELIM bytes) is to be written through cfg_ only while
// idle; the block itself does not enforce this. A result moves from the
// engine step through the hold register, which it leaves once the transaction
// is finished or a newer result arrives, into the output register. The engine
// does one window step, one flushed byte or the end marker per cycle while the
// output stage lets it, and takes the next transaction at the edge of its last
// step. A byte in the middle of a row needs one step, so such transactions
// flow at one per cycle. A row end adds one step per flushed byte and one for
// the end marker; a delimiter length lowered mid-row adds window steps.
// A stalled receiver holds the output register, then the hold register,
// then the engine and finally in_tready; nothing is dropped.
// Reset (rst_n low at a clock edge) empties the pipeline, clears the window
// and row state and sets the delimiter to length one, all bytes zero.
module delimited_field_extractor #(
  parameter int MAX_DELIM = dfx_pkg::MAX_DELIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // data_byte[7:0], row_start[8], field_index[24:9], zero above
  input  logic [dfx_pkg::IN_TDATA_W-1:0]     in_tdata,
  // byte_present[0], row_is_null[1]
  input  logic [dfx_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_byte[7:0], last[8], zero above
  output logic [dfx_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_byte_valid[0], result_null[1]
  output logic [dfx_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [dfx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dfx_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dfx_pkg::*;

  localparam int FW = $clog2(MAX_DELIM + 1);

  logic [DELIM_W-1:0] delim;
  logic [FW-1:0]      eff_len;
  item_t              in_item;
  eng_out_t           eo;
  logic               step_ok;
  res_t               o_res;
  logic               o_last;

  assign in_item.data_byte    = in_tdata[DATA_W-1:0];
  assign in_item.row_start    = in_tdata[DATA_W];
  assign in_item.field_index  = in_tdata[DATA_W+1 +: FIDX_W];
  assign in_item.byte_present = in_tuser[0];
  assign in_item.row_is_null  = in_tuser[1];
  assign in_item.row_end      = in_tlast;

  dfx_cfg #(
    .MAX_DELIM (MAX_DELIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .delim     (delim),
    .eff_len   (eff_len)
  );

  dfx_engine #(
    .MAX_DELIM (MAX_DELIM)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .delim    (delim),
    .len      (eff_len),
    .step_ok  (step_ok),
    .eo       (eo)
  );

  dfx_tagger u_tagger (
    .clk       (clk),
    .rst_n     (rst_n),
    .eo        (eo),
    .step_ok   (step_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (o_res),
    .out_last  (o_last)
  );

  assign out_tdata = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, o_last, o_res.data};
  assign out_tuser = {o_res.res_null, o_res.byte_vld};
  assign out_tlast = o_res.res_end;

endmodule

// File: src/dfx_cfg.sv
`timescale 1ns / 1ps
// Configuration registers of the delimited field extractor.
// Holds the delimiter bytes and length and clamps the length; uses dfx_pkg.
module dfx_cfg #(
  parameter int MAX_DELIM = dfx_pkg::MAX_DELIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [dfx_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dfx_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  output logic [dfx_pkg::DELIM_W-1:0]            delim,
  output logic [$clog2(MAX_DELIM+1)-1:0]         eff_len
);
  import dfx_pkg::*;

  localparam int FW = $clog2(MAX_DELIM + 1);

  logic [DELIM_W-1:0] delim_r;
  logic [LEN_W-1:0]   len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= '0;
      len_r   <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELIM_BYTES: delim_r <= cfg_wdata[DELIM_W-1:0];
        CFG_DELIM_LEN:   len_r   <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  // A length of zero acts as one; anything above the window size is clipped.
  always_comb begin
    if (len_r == '0) begin
      eff_len = FW'(1);
    end else if (len_r > LEN_W'(MAX_DELIM)) begin
      eff_len = FW'(MAX_DELIM);
    end else begin
      eff_len = FW'(len_r);
    end
  end

  assign delim = delim_r;

endmodule

// File: src/dfx_engine.sv
`timescale 1ns / 1ps
// Window engine: holds the current item, the match window and the row state,
// and performs one window step per cycle unless step_ok stalls it. Uses dfx_pkg.
module dfx_engine #(
  parameter int MAX_DELIM = dfx_pkg::MAX_DELIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dfx_pkg::item_t                 in_item,
  input  logic [dfx_pkg::DELIM_W-1:0]    delim,
  input  logic [$clog2(MAX_DELIM+1)-1:0] len,
  input  logic                           step_ok,
  output dfx_pkg::eng_out_t              eo
);
  import dfx_pkg::*;

  localparam int FW = $clog2(MAX_DELIM + 1);
  localparam int WW = DATA_W * MAX_DELIM;

  item_t             item_r;
  logic              item_vld_r;
  logic              pend_r;
  logic [WW-1:0]     win_r;
  logic [FW-1:0]     fill_r;
  logic [FNUM_W-1:0] fnum_r;
  logic [FIDX_W-1:0] tgt_r;
  logic              nul_r;

  logic [WW-1:0]     s_win,  win_nxt;
  logic [FW-1:0]     s_fill, fill_nxt;
  logic [FNUM_W-1:0] s_fnum, fnum_nxt;
  logic [FIDX_W-1:0] s_tgt;
  logic              s_nul,  nul_nxt;
  logic              sel;
  logic              match;
  logic              step;
  logic              in_fire;

  always_comb begin
    // Row start, null flag and the byte push of a fresh item.
    s_win  = win_r;
    s_fill = fill_r;
    s_fnum = fnum_r;
    s_tgt  = tgt_r;
    s_nul  = nul_r;
    if (pend_r) begin
      if (item_r.row_start) begin
        s_fnum = FNUM_W'(1);
        s_fill = '0;
        s_tgt  = item_r.field_index;
        s_nul  = 1'b0;
      end
      s_nul = s_nul | item_r.row_is_null;
      if (item_r.byte_present && s_fill < FW'(MAX_DELIM)) begin
        for (int i = 0; i < MAX_DELIM; i++) begin
          if (s_fill == FW'(i)) begin
            s_win[i*DATA_W +: DATA_W] = item_r.data_byte;
          end
        end
        s_fill = s_fill + FW'(1);
      end
    end

    sel = !s_nul && s_tgt != '0 && s_fnum == {1'b0, s_tgt};

    match = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if (FW'(i) < len && s_win[i*DATA_W +: DATA_W] != delim[i*DATA_W +: DATA_W]) begin
        match = 1'b0;
      end
    end

    win_nxt  = s_win;
    fill_nxt = s_fill;
    fnum_nxt = s_fnum;
    nul_nxt  = s_nul;
    eo       = '0;
    eo.busy  = item_vld_r;

    if (s_fill >= len) begin
      if (match) begin
        if (s_fnum != FIELD_MAX) begin
          fnum_nxt = s_fnum + FNUM_W'(1);
        end
        win_nxt  = s_win >> {len, 3'b000};
        fill_nxt = s_fill - len;
      end else begin
        // The oldest byte cannot start a delimiter and leaves the window.
        eo.vld          = item_vld_r && sel;
        eo.res.data     = s_win[DATA_W-1:0];
        eo.res.byte_vld = 1'b1;
        win_nxt         = s_win >> DATA_W;
        fill_nxt        = s_fill - FW'(1);
      end
      eo.done = item_vld_r && !item_r.row_end && fill_nxt < len;
    end else if (item_r.row_end) begin
      if (sel && s_fill != '0) begin
        // Flush the window into the selected field, one byte per cycle unless stalled.
        eo.vld          = item_vld_r;
        eo.res.data     = s_win[DATA_W-1:0];
        eo.res.byte_vld = 1'b1;
        win_nxt         = s_win >> DATA_W;
        fill_nxt        = s_fill - FW'(1);
      end else begin
        eo.vld          = item_vld_r;
        eo.done         = item_vld_r;
        eo.res.res_end  = 1'b1;
        eo.res.res_null = s_nul || s_tgt == '0 || s_fnum < {1'b0, s_tgt};
        fill_nxt        = '0;
        fnum_nxt        = FNUM_W'(1);
        nul_nxt         = 1'b0;
      end
    end else begin
      eo.done = item_vld_r;
    end
  end

  assign step     = item_vld_r && step_ok;
  // Nothing is taken while reset is held.
  assign in_ready = rst_n && (!item_vld_r || (step && eo.done));
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      pend_r     <= 1'b0;
      win_r      <= '0;
      fill_r     <= '0;
      fnum_r     <= FNUM_W'(1);
      tgt_r      <= '0;
      nul_r      <= 1'b0;
    end else begin
      if (step) begin
        win_r  <= win_nxt;
        fill_r <= fill_nxt;
        fnum_r <= fnum_nxt;
        tgt_r  <= s_tgt;
        nul_r  <= nul_nxt;
        pend_r <= 1'b0;
        if (eo.done) begin
          item_vld_r <= 1'b0;
        end
      end
      if (in_fire) begin
        item_vld_r <= 1'b1;
        pend_r     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_DELIM))
    else $error("window fill exceeds window size");

  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    (step && eo.vld && eo.res.res_end) |=>
      (fill_r == '0 && fnum_r == FNUM_W'(1) && !nul_r))
    else $error("row state not cleared after end marker");

endmodule

// File: src/dfx_tagger.sv
`timescale 1ns / 1ps
// Output stage: a hold register that settles the last-result flag of each
// item, followed by the output register. Uses dfx_pkg.
module dfx_tagger (
  input  logic              clk,
  input  logic              rst_n,
  input  dfx_pkg::eng_out_t eo,
  output logic              step_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output dfx_pkg::res_t     out_res,
  output logic              out_last
);
  import dfx_pkg::*;

  logic h_vld_r;
  logic h_fin_r;
  res_t h_res_r;
  logic o_vld_r;
  logic o_last_r;
  res_t o_res_r;

  logic out_free;
  logic h_move;
  logic step;

  // A held result may leave once it is known to be the item's last one,
  // or once a newer result of the same item arrives behind it.
  assign out_free = !o_vld_r || out_ready;
  assign h_move   = h_vld_r && (h_fin_r || eo.vld) && out_free;
  assign step_ok  = !eo.vld || !h_vld_r || h_move;
  assign step     = eo.busy && step_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      h_fin_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (step && eo.vld) begin
        h_vld_r <= 1'b1;
        h_fin_r <= eo.done;
      end else if (h_move) begin
        h_vld_r <= 1'b0;
      end else if (step && eo.done && h_vld_r) begin
        h_fin_r <= 1'b1;
      end

      if (h_move) begin
        o_vld_r <= 1'b1;
      end else if (out_ready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && eo.vld) begin
      h_res_r <= eo.res;
    end
    if (h_move) begin
      o_res_r  <= h_res_r;
      o_last_r <= h_fin_r;
    end
  end

  assign out_valid = o_vld_r;
  assign out_res   = o_res_r;
  assign out_last  = o_last_r;

  a_marker_final: assert property (@(posedge clk) disable iff (!rst_n)
    (h_move && h_res_r.res_end) |-> h_fin_r)
    else $error("end marker released without last flag");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (h_vld_r && !h_fin_r && !eo.vld) |=> h_vld_r)
    else $error("unsettled result left the hold register");

endmodule
